// ===== hw/rtl/irt_pkg.sv =====
package irt_pkg;

    localparam int TABLES  = 7;
    localparam int ENTRIES = 32;
    localparam int VW      = 48;
    localparam int TSEL_W  = 3;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TIDX_W  = (TABLES > 1) ? $clog2(TABLES) : 1;

    typedef logic [VW-1:0] t_val;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_MAP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LCMP,
        ST_LUPD,
        ST_WLOAD,
        ST_WALK
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_UPD,
        CELL_WLOAD,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [TIDX_W-1:0]   tidx;
        logic [CNT_W-1:0]    count;
        logic                found;
        t_val                s;
        t_val                d;
        t_val                len;
    } t_cell_ctrl;

    typedef struct packed {
        t_val es;
        t_val ee;
        t_val off;
        logic zero;
    } t_walk;

endpackage

// ===== hw/rtl/irt_cell.sv =====
module irt_cell import irt_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]  i_idx,
    input  logic              i_lt_left,
    input  t_val              i_src_left,
    input  t_val              i_dst_left,
    input  t_val              i_len_left,
    input  t_walk             i_walk_right,
    output logic              o_lt,
    output logic              o_eq,
    output t_val              o_src,
    output t_val              o_dst,
    output t_val              o_len,
    output t_walk             o_walk
);

    t_val  r_src [TABLES];
    t_val  r_dst [TABLES];
    t_val  r_len [TABLES];
    logic  r_lt;
    logic  r_eq;
    t_walk r_walk;

    logic          in_range;
    logic          insert_here;
    logic          shift_here;
    logic [VW:0]   ee_sum;
    t_walk         n_walk;

    assign o_src  = r_src[i_ctrl.tidx];
    assign o_dst  = r_dst[i_ctrl.tidx];
    assign o_len  = r_len[i_ctrl.tidx];
    assign o_walk = r_walk;

    assign in_range    = i_idx < i_ctrl.count;
    assign o_lt        = r_lt && in_range;
    assign o_eq        = r_eq && in_range;
    // left neighbor below the new key and this one not: insertion point
    assign insert_here = i_lt_left && !o_lt;
    assign shift_here  = !i_lt_left && (i_idx <= i_ctrl.count);

    // covered range end, saturating at the top value
    assign ee_sum = {1'b0, o_src} + {1'b0, o_len - t_val'(1)};

    always_comb begin
        n_walk.es   = o_src;
        n_walk.ee   = ee_sum[VW] ? '1 : ee_sum[VW-1:0];
        n_walk.off  = o_dst - o_src;
        n_walk.zero = (o_len == '0);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            CELL_CMP: begin
                r_lt <= o_src < i_ctrl.s;
                r_eq <= o_src == i_ctrl.s;
            end
            CELL_UPD: begin
                if (i_ctrl.found) begin
                    if (o_eq) begin
                        r_dst[i_ctrl.tidx] <= i_ctrl.d;
                        r_len[i_ctrl.tidx] <= i_ctrl.len;
                    end
                end else if (insert_here) begin
                    r_src[i_ctrl.tidx] <= i_ctrl.s;
                    r_dst[i_ctrl.tidx] <= i_ctrl.d;
                    r_len[i_ctrl.tidx] <= i_ctrl.len;
                end else if (shift_here) begin
                    r_src[i_ctrl.tidx] <= i_src_left;
                    r_dst[i_ctrl.tidx] <= i_dst_left;
                    r_len[i_ctrl.tidx] <= i_len_left;
                end
            end
            CELL_WLOAD: r_walk <= n_walk;
            CELL_SHIFT: r_walk <= i_walk_right;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/interval_remap_table.sv =====
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   kind, table_select, source_start, dest_start,
//                                               span_length, range_low, range_high
// out      output     o_out_valid / i_out_stall out_low, out_high, last, status
//
// one request at a time; a load compares in all cells, then updates them; clear and pass-through map
// answer straight from idle; a map loads the walk chain, then at each step skips an entry by
// shifting the walk chain or emits a piece, until the last piece is emitted
// synchronous active-low reset empties all tables; entry storage is not cleared
// a stalled output holds the engine; new requests wait until the engine is idle
module interval_remap_table import irt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [TSEL_W-1:0] i_table_select,
    input  logic [VW-1:0]     i_source_start,
    input  logic [VW-1:0]     i_dest_start,
    input  logic [VW-1:0]     i_span_length,
    input  logic [VW-1:0]     i_range_low,
    input  logic [VW-1:0]     i_range_high,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VW-1:0]     o_out_low,
    output logic [VW-1:0]     o_out_high,
    output logic              o_last,
    output logic              o_status
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt [TABLES];
    logic [TIDX_W-1:0] r_t;
    t_val r_s, r_d, r_len, r_lo, r_hi;
    logic [CNT_W-1:0] r_i, r_k;
    logic r_ov, r_last, r_st;
    t_val r_olo, r_ohi;

    logic free, accept, t_ok;
    logic [CNT_W-1:0] cur_cnt;
    logic emit, e_last, e_st;
    t_val e_lo, e_hi;
    t_cell_op op;
    t_cell_ctrl ctrl;
    logic found, full;
    logic cnt_inc, cnt_clr, lo_set, k_inc, i_inc;
    t_val lo_next;
    t_walk h;

    logic  lt   [ENTRIES];
    logic  eq   [ENTRIES];
    t_val  srcv [ENTRIES];
    t_val  dstv [ENTRIES];
    t_val  lenv [ENTRIES];
    t_walk wv   [ENTRIES];
    logic [ENTRIES-1:0] eq_vec;

    assign free       = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && free);
    assign accept     = i_in_valid && !o_in_stall;
    assign t_ok       = i_table_select < TSEL_W'(TABLES);
    assign cur_cnt    = r_cnt[r_t];
    assign h          = wv[0];
    assign full       = cur_cnt >= CNT_W'(ENTRIES);

    always_comb begin
        ctrl.op    = op;
        ctrl.tidx  = r_t;
        ctrl.count = cur_cnt;
        ctrl.found = found;
        ctrl.s     = r_s;
        ctrl.d     = r_d;
        ctrl.len   = r_len;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign eq_vec[g] = eq[g];
            irt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_idx        (CNT_W'(g)),
                .i_lt_left    ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
                .i_src_left   (srcv[(g == 0) ? 0 : g - 1]),
                .i_dst_left   (dstv[(g == 0) ? 0 : g - 1]),
                .i_len_left   (lenv[(g == 0) ? 0 : g - 1]),
                .i_walk_right (wv[(g == ENTRIES - 1) ? g : g + 1]),
                .o_lt         (lt[g]),
                .o_eq         (eq[g]),
                .o_src        (srcv[g]),
                .o_dst        (dstv[g]),
                .o_len        (lenv[g]),
                .o_walk       (wv[g])
            );
        end
    endgenerate

    assign found = |eq_vec;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_kind'(i_kind) == KIND_LOAD && t_ok) begin
                        n_state = ST_LCMP;
                    end else if (t_kind'(i_kind) == KIND_MAP && t_ok
                                 && i_range_low <= i_range_high) begin
                        n_state = ST_WLOAD;
                    end
                end
            end
            ST_LCMP:  n_state = ST_LUPD;
            ST_LUPD:  if (free) n_state = ST_IDLE;
            ST_WLOAD: n_state = ST_WALK;
            ST_WALK:  if (emit && e_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        op      = CELL_HOLD;
        emit    = 1'b0;
        e_lo    = '0;
        e_hi    = '0;
        e_last  = 1'b1;
        e_st    = 1'b0;
        cnt_inc = 1'b0;
        cnt_clr = 1'b0;
        lo_set  = 1'b0;
        lo_next = r_lo;
        k_inc   = 1'b0;
        i_inc   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        KIND_LOAD: begin
                            if (!t_ok) begin
                                emit = 1'b1;
                                e_st = 1'b1;
                            end
                        end
                        KIND_MAP: begin
                            if (!t_ok || i_range_low > i_range_high) begin
                                emit = 1'b1;
                                e_lo = i_range_low;
                                e_hi = i_range_high;
                            end
                        end
                        KIND_CLEAR: begin
                            emit    = 1'b1;
                            cnt_clr = t_ok;
                        end
                        KIND_NONE: ;
                        default: ;
                    endcase
                end
            end
            ST_LCMP: op = CELL_CMP;
            ST_LUPD: begin
                if (free) begin
                    emit = 1'b1;
                    e_st = full && !found;
                    if (found || !full) op = CELL_UPD;
                    cnt_inc = !found && !full;
                end
            end
            ST_WLOAD: op = CELL_WLOAD;
            ST_WALK: begin
                if (free) begin
                    if (r_i == cur_cnt) begin
                        emit = 1'b1;
                        e_lo = r_lo;
                        e_hi = r_hi;
                    end else if (h.zero || (r_lo >= h.es && r_lo > h.ee)) begin
                        op    = CELL_SHIFT;
                        i_inc = 1'b1;
                    end else if (r_lo < h.es) begin
                        emit = 1'b1;
                        if (r_hi < h.es) begin
                            e_lo = r_lo;
                            e_hi = r_hi;
                        end else if (r_k == CNT_W'(ENTRIES)) begin
                            e_lo = r_lo;
                            e_hi = r_hi;
                            e_st = 1'b1;
                        end else begin
                            e_lo    = r_lo;
                            e_hi    = h.es - t_val'(1);
                            e_last  = 1'b0;
                            lo_set  = 1'b1;
                            lo_next = h.es;
                            k_inc   = 1'b1;
                        end
                    end else begin
                        emit = 1'b1;
                        if (r_hi <= h.ee) begin
                            e_lo = r_lo + h.off;
                            e_hi = r_hi + h.off;
                        end else if (r_k == CNT_W'(ENTRIES)) begin
                            e_lo = r_lo;
                            e_hi = r_hi;
                            e_st = 1'b1;
                        end else begin
                            e_lo    = r_lo + h.off;
                            e_hi    = h.ee + h.off;
                            e_last  = 1'b0;
                            lo_set  = 1'b1;
                            lo_next = h.ee + t_val'(1);
                            k_inc   = 1'b1;
                            op      = CELL_SHIFT;
                            i_inc   = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int j = 0; j < TABLES; j++) r_cnt[j] <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (cnt_clr) begin
                r_cnt[i_table_select[TIDX_W-1:0]] <= '0;
            end else if (cnt_inc) begin
                r_cnt[r_t] <= cur_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_olo  <= e_lo;
            r_ohi  <= e_hi;
            r_last <= e_last;
            r_st   <= e_st;
        end
        if (accept) begin
            r_t   <= i_table_select[TIDX_W-1:0];
            r_s   <= i_source_start;
            r_d   <= i_dest_start;
            r_len <= i_span_length;
            r_lo  <= i_range_low;
            r_hi  <= i_range_high;
            r_i   <= '0;
            r_k   <= '0;
        end else begin
            if (lo_set) r_lo <= lo_next;
            if (k_inc)  r_k  <= r_k + CNT_W'(1);
            if (i_inc)  r_i  <= r_i + CNT_W'(1);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_low   = r_olo;
    assign o_out_high  = r_ohi;
    assign o_last      = r_last;
    assign o_status    = r_st;

endmodule

// ===== bench/irt_checker.sv =====
module irt_checker import irt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [TSEL_W-1:0] i_table_select,
    input  logic [VW-1:0]     i_source_start,
    input  logic [VW-1:0]     i_dest_start,
    input  logic [VW-1:0]     i_span_length,
    input  logic [VW-1:0]     i_range_low,
    input  logic [VW-1:0]     i_range_high,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [VW-1:0]     i_out_low,
    input  logic [VW-1:0]     i_out_high,
    input  logic              i_last,
    input  logic              i_status,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_val lo;
        t_val hi;
        logic last;
        logic status;
    } t_piece;

    t_val   tbl_src [TABLES][ENTRIES];
    t_val   tbl_dst [TABLES][ENTRIES];
    t_val   tbl_len [TABLES][ENTRIES];
    int     tbl_cnt [TABLES];
    t_piece pieces_due [$];

    localparam t_val VMAX = '1;

    function automatic t_piece mk(t_val lo, t_val hi, logic last, logic status);
        t_piece p;
        p.lo = lo;
        p.hi = hi;
        p.last = last;
        p.status = status;
        return p;
    endfunction

    function automatic void queue_piece(t_piece p);
        pieces_due = {pieces_due, p};
    endfunction

    function automatic logic load_entry(int t, t_val s, t_val d, t_val len);
        int n;
        int pos;
        n = tbl_cnt[t];
        pos = 0;
        while (pos < n && tbl_src[t][pos] < s) pos++;
        if (pos < n && tbl_src[t][pos] == s) begin
            tbl_dst[t][pos] = d;
            tbl_len[t][pos] = len;
            return 1'b0;
        end
        if (n >= ENTRIES) return 1'b1;
        for (int j = n; j > pos; j--) begin
            tbl_src[t][j] = tbl_src[t][j-1];
            tbl_dst[t][j] = tbl_dst[t][j-1];
            tbl_len[t][j] = tbl_len[t][j-1];
        end
        tbl_src[t][pos] = s;
        tbl_dst[t][pos] = d;
        tbl_len[t][pos] = len;
        tbl_cnt[t] = n + 1;
        return 1'b0;
    endfunction

    task automatic remap_range(int t, t_val lo, t_val hi);
        int k;
        t_val es;
        t_val ds;
        t_val len;
        t_val ee;
        k = 0;
        if (t >= TABLES || lo > hi) begin
            queue_piece(mk(lo, hi, 1, 0));
            return;
        end
        for (int i = 0; i < tbl_cnt[t]; i++) begin
            es = tbl_src[t][i];
            ds = tbl_dst[t][i];
            len = tbl_len[t][i];
            if (len == 0) continue;
            ee = (len - 1 > VMAX - es) ? VMAX : es + len - 1;
            if (lo < es) begin
                if (hi < es) begin
                    queue_piece(mk(lo, hi, 1, 0));
                    return;
                end
                if (k == ENTRIES) begin
                    queue_piece(mk(lo, hi, 1, 1));
                    return;
                end
                queue_piece(mk(lo, es - 1, 0, 0));
                k++;
                lo = es;
            end
            if (lo <= ee) begin
                if (hi <= ee) begin
                    queue_piece(mk(ds + (lo - es), ds + (hi - es), 1, 0));
                    return;
                end
                if (k == ENTRIES) begin
                    queue_piece(mk(lo, hi, 1, 1));
                    return;
                end
                queue_piece(mk(ds + (lo - es), ds + (ee - es), 0, 0));
                k++;
                lo = ee + 1;
            end
        end
        queue_piece(mk(lo, hi, 1, 0));
    endtask

    initial begin
        o_fail_count = 0;
        foreach (tbl_cnt[t]) tbl_cnt[t] = 0;
    end

    assign o_pending = pieces_due.size();

    always @(posedge i_clk) begin
        t_piece got;
        t_piece want;
        logic st;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            case (t_kind'(i_kind))
                KIND_LOAD: begin
                    st = 1'b1;
                    if (i_table_select < TABLES)
                        st = load_entry(i_table_select, i_source_start, i_dest_start,
                                        i_span_length);
                    queue_piece(mk(0, 0, 1, st));
                end
                KIND_MAP: remap_range(i_table_select, i_range_low, i_range_high);
                KIND_CLEAR: begin
                    if (i_table_select < TABLES) tbl_cnt[i_table_select] = 0;
                    queue_piece(mk(0, 0, 1, 0));
                end
                default: ;
            endcase
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = mk(i_out_low, i_out_high, i_last, i_status);
            if (pieces_due.size() == 0) begin
                $display("%t unexpected result: got %h/%h last %b status %b", $time,
                         got.lo, got.hi, got.last, got.status);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = pieces_due.pop_front();
                if (got !== want) begin
                    $display("%t mismatch: expected %h/%h last %b status %b, got %h/%h last %b status %b",
                             $time, want.lo, want.hi, want.last, want.status,
                             got.lo, got.hi, got.last, got.status);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
module tb_top import irt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [1:0]        kind = '0;
    logic [TSEL_W-1:0] tsel = '0;
    t_val              src = '0, dst = '0, len = '0, rlo = '0, rhi = '0;
    logic              out_valid;
    logic              out_stall = 0;
    t_val              out_low, out_high;
    logic              last, status;
    int                fail_count, pending;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    interval_remap_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_table_select(tsel), .i_source_start(src),
        .i_dest_start(dst), .i_span_length(len), .i_range_low(rlo),
        .i_range_high(rhi),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_low(out_low), .o_out_high(out_high), .o_last(last), .o_status(status)
    );

    irt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_table_select(tsel), .i_source_start(src),
        .i_dest_start(dst), .i_span_length(len), .i_range_low(rlo),
        .i_range_high(rhi),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_low(out_low), .i_out_high(out_high), .i_last(last), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic t_val rand_val();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return t_val'($urandom_range(0, 300));
            3: return '1 - t_val'($urandom_range(0, 300));
            default: return t_val'({$urandom, $urandom});
        endcase
    endfunction

    // one request, held until accepted, then sometimes an idle gap
    task automatic send(t_kind k, int t, t_val s, t_val d, t_val l, t_val lo, t_val hi);
        int gap;
        kind = k;
        tsel = TSEL_W'(t);
        src = s;
        dst = d;
        len = l;
        rlo = lo;
        rhi = hi;
        in_valid = 1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // small-numbered ranges so entries overlap the maps
    task automatic rand_item();
        int t;
        t_val base;
        t = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 2);
        base = $urandom_range(0, 7) == 0 ? rand_val() : t_val'($urandom_range(0, 2000));
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
                send(KIND_LOAD, t, base, rand_val(),
                     $urandom_range(0, 7) == 0 ? rand_val() : t_val'($urandom_range(0, 150)),
                     0, 0);
            8: send(KIND_CLEAR, t, rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
            9: send(KIND_NONE, t, rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
            default:
                send(KIND_MAP, t, rand_val(), rand_val(), rand_val(), base,
                     $urandom_range(0, 9) == 0 ? rand_val() : base + $urandom_range(0, 2500));
        endcase
    endtask

    always @(negedge i_clk) begin
        int hold;
        if (i_rst_n) begin
            if (hold > 0) begin
                hold--;
            end else if (out_stall) begin
                out_stall <= 0;
            end else if (out_valid) begin
                hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
                if (hold > 0) begin
                    out_stall <= 1;
                    hold--;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        // extremes and special cases
        send(KIND_MAP, 0, 0, 0, 0, 0, '1);
        send(KIND_LOAD, 0, 100, 1000, 10, 0, 0);
        send(KIND_LOAD, 0, 105, 5000, 10, 0, 0);
        send(KIND_LOAD, 0, 50, 7, 0, 0, 0);
        send(KIND_LOAD, 0, '1 - 4, 3, '1, 0, 0);
        send(KIND_LOAD, 0, 0, '1, 1, 0, 0);
        send(KIND_MAP, 0, 0, 0, 0, 0, '1);
        send(KIND_MAP, 0, 0, 0, 0, 103, 103);
        send(KIND_MAP, 0, 0, 0, 0, 20, 10);
        send(KIND_LOAD, 0, 100, 2000, 3, 0, 0);
        send(KIND_MAP, 0, 0, 0, 0, 90, 120);
        send(KIND_LOAD, 7, 1, 1, 1, 0, 0);
        send(KIND_MAP, 7, 0, 0, 0, 5, 9);
        send(KIND_CLEAR, 7, 0, 0, 0, 0, 0);
        send(KIND_NONE, 0, '1, '1, '1, '1, '1);
        for (int i = 0; i < ENTRIES + 1; i++)
            send(KIND_LOAD, 1, t_val'(i * 4), t_val'(i), 2, 0, 0);
        send(KIND_LOAD, 1, 8, 77, 2, 0, 0);
        send(KIND_MAP, 1, 0, 0, 0, 0, '1);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0);
        send(KIND_MAP, 0, 0, 0, 0, 3, 4);
        repeat (358) rand_item();
        in_valid = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
